// ===== src/cnc_srp_pkg.sv =====
// Package for the CNC status report parser: word types, character and
// phase codes, sizing constants and small constant tables.
// No dependencies; imported by cnc_status_report_parser_unit.
package cnc_srp_pkg;

    // Sizing constants.
    localparam int MAX_MSG_LEN      = 64;
    localparam int STATE_WORD_LIMIT = 20;
    localparam int FRAC_DIGITS      = 3;
    localparam int NUM_NAMES        = 7;
    localparam int NAME_MAX_LEN     = 5;
    localparam int TAG_LEN          = 5;

    localparam int BYTE_CNT_W  = $clog2(MAX_MSG_LEN + 1);
    localparam int NAME_LEN_W  = $clog2(STATE_WORD_LIMIT + 1);
    localparam int FRAC_CNT_W  = $clog2(FRAC_DIGITS + 1);
    localparam int TAG_CNT_W   = $clog2(TAG_LEN + 1);
    localparam int POS_W       = 28;
    localparam int MAG_W       = 27;
    localparam int SUM_W       = 31;
    localparam int POW_W       = 17;

    localparam logic [MAG_W-1:0] POS_LIMIT = MAG_W'(99999999);

    // Machine state codes.
    localparam logic [2:0] MS_UNKNOWN = 3'd0;
    localparam logic [2:0] MS_IDLE    = 3'd1;
    localparam logic [2:0] MS_RUN     = 3'd2;
    localparam logic [2:0] MS_JOG     = 3'd3;
    localparam logic [2:0] MS_HOLD    = 3'd4;
    localparam logic [2:0] MS_ALARM   = 3'd5;
    localparam logic [2:0] MS_CHECK   = 3'd6;
    localparam logic [2:0] MS_WORK    = 3'd7;

    // State name phases.
    localparam logic [1:0] NP_WAIT = 2'd0;
    localparam logic [1:0] NP_NAME = 2'd1;
    localparam logic [1:0] NP_DONE = 2'd2;

    // Number scanner phases within one axis.
    localparam logic [2:0] NS_START = 3'd0;
    localparam logic [2:0] NS_SIGN  = 3'd1;
    localparam logic [2:0] NS_DOT   = 3'd2;
    localparam logic [2:0] NS_INT   = 3'd3;
    localparam logic [2:0] NS_FRAC  = 3'd4;

    // Axis codes.
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_OPEN  = "<";
    localparam logic [7:0] CH_BAR   = "|";
    localparam logic [7:0] CH_COMMA = ",";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_M     = "M";

    // State names, padded with zero bytes, and their lengths.
    localparam logic [7:0] NAME_TEXT [NUM_NAMES][NAME_MAX_LEN] = '{
        '{"I", "d", "l", "e", 8'h00},
        '{"R", "u", "n", 8'h00, 8'h00},
        '{"J", "o", "g", 8'h00, 8'h00},
        '{"H", "o", "l", "d", 8'h00},
        '{"A", "l", "a", "r", "m"},
        '{"C", "h", "e", "c", "k"},
        '{"W", "o", "r", "k", 8'h00}
    };
    localparam logic [2:0] NAME_LEN [NUM_NAMES] = '{3'd4, 3'd3, 3'd3, 3'd4, 3'd5, 3'd5, 3'd4};

    // Position tag that opens the number fields.
    localparam logic [7:0] TAG_TEXT [TAG_LEN] = '{"M", "P", "o", "s", ":"};

    // Input word: one character of the report.
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       last_byte;
    } msg_word_t;

    // Output word: one result per report.
    typedef struct packed {
        logic [2:0]              machine_state;
        logic                    state_updated;
        logic                    pos_updated;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } rpt_word_t;

    // Powers of ten used for digit weights.
    function automatic logic [POW_W-1:0] pow10(input int n);
        logic [POW_W-1:0] p;
        case (n)
            0:       p = POW_W'(1);
            1:       p = POW_W'(10);
            2:       p = POW_W'(100);
            3:       p = POW_W'(1000);
            4:       p = POW_W'(10000);
            default: p = POW_W'(1);
        endcase
        return p;
    endfunction

endpackage

// ===== src/cnc_status_report_parser_unit.sv =====
// Top level of the CNC status report parser: byte input stage, running
// parse state and the registered result word.
// Depends on cnc_srp_pkg.

// The block takes a status report on the msg channel one byte per word,
// with last_byte set on the final byte of the report. For every last byte it
// delivers exactly one word on the rpt channel carrying the held machine
// state, the held X/Y/Z positions in thousandths and two flags telling
// whether this report updated the state and the positions.
// Both channels use valid and stall; a word moves at a clock edge where
// valid is high and stall is low.
// Throughput is one byte per cycle while msg_stall is low: one pass of logic
// updates the parse state registers from the input register.
// The last byte is parsed from the input register and the result word is
// registered in the result register, which drives rpt_valid.
// When the receiver stalls, the result register holds its word; bytes that
// produce no result keep flowing, and only a second last byte waits in the
// input register, raising msg_stall until the result is taken.
// Reset (rst_n low) clears the report state, sets the held state to unknown
// and the held positions to zero; no result is pending after reset.
module cnc_status_report_parser_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   msg_valid,
    output logic                   msg_stall,
    input  cnc_srp_pkg::msg_word_t msg,
    output logic                   rpt_valid,
    input  logic                   rpt_stall,
    output cnc_srp_pkg::rpt_word_t rpt
);
    import cnc_srp_pkg::*;

    // Input stage.
    logic      in_valid_reg;
    logic      in_valid_next;
    msg_word_t in_reg;
    logic      in_go;

    // Per-report state.
    logic [BYTE_CNT_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic                  text_ended_reg, text_ended_next;
    logic [1:0]            name_phase_reg, name_phase_next;
    logic [NUM_NAMES-1:0]  name_cand_reg, name_cand_next;
    logic [NAME_LEN_W-1:0] name_len_reg, name_len_next;
    logic [TAG_CNT_W-1:0]  tag_cnt_reg, tag_cnt_next;
    logic                  num_active_reg, num_active_next;
    logic [1:0]            num_axis_reg, num_axis_next;
    logic [2:0]            num_sub_reg, num_sub_next;
    logic [MAG_W-1:0]      mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic [FRAC_CNT_W-1:0] frac_cnt_reg, frac_cnt_next;
    logic [POS_W-1:0]      pend_x_reg, pend_x_next;
    logic [POS_W-1:0]      pend_y_reg, pend_y_next;
    logic                  state_upd_reg, state_upd_next;
    logic                  pos_upd_reg, pos_upd_next;

    // Held results.
    logic [2:0]       held_state_reg, held_state_next;
    logic [POS_W-1:0] held_x_reg, held_x_next;
    logic [POS_W-1:0] held_y_reg, held_y_next;
    logic [POS_W-1:0] held_z_reg, held_z_next;

    // Output register.
    logic      rpt_valid_reg, rpt_valid_next;
    rpt_word_t rpt_reg, rpt_next;

    // The input stage moves on unless it holds a last byte and the result
    // register is full and stalled.
    assign in_go     = in_valid_reg
                       && (!in_reg.last_byte || !rpt_valid_reg || !rpt_stall);
    assign msg_stall = in_valid_reg && !in_go;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (msg_valid && !msg_stall)
        begin
            in_valid_next = 1'b1;
        end
        else if (in_go)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Parse one byte: state name matcher, position tag search, number scanner.
    always_comb
    begin
        logic [7:0]             c;
        logic                   is_digit;
        logic [3:0]             dval;
        logic                   feed;
        logic                   do_end;
        logic                   found;
        logic [SUM_W-1:0]       int_sum;
        logic [SUM_W-1:0]       frac_sum;
        logic [MAG_W-1:0]       int_mag;
        logic [MAG_W-1:0]       frac_mag;
        logic [POS_W-1:0]       cur_value;
        logic [POS_W-1:0]       end_value;
        logic [BYTE_CNT_W:0]    cnt_inc;

        byte_cnt_next   = byte_cnt_reg;
        text_ended_next = text_ended_reg;
        name_phase_next = name_phase_reg;
        name_cand_next  = name_cand_reg;
        name_len_next   = name_len_reg;
        tag_cnt_next    = tag_cnt_reg;
        num_active_next = num_active_reg;
        num_axis_next   = num_axis_reg;
        num_sub_next    = num_sub_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        frac_cnt_next   = frac_cnt_reg;
        pend_x_next     = pend_x_reg;
        pend_y_next     = pend_y_reg;
        state_upd_next  = state_upd_reg;
        pos_upd_next    = pos_upd_reg;
        held_state_next = held_state_reg;
        held_x_next     = held_x_reg;
        held_y_next     = held_y_reg;
        held_z_next     = held_z_reg;
        rpt_next        = rpt_reg;
        rpt_valid_next  = rpt_valid_reg && rpt_stall;

        c        = in_reg.msg_byte;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        dval     = 4'(c - CH_ZERO);
        cnt_inc  = (BYTE_CNT_W + 1)'(byte_cnt_reg) + 1'b1;
        feed     = !text_ended_reg && (c != CH_NUL)
                   && (byte_cnt_reg < BYTE_CNT_W'(MAX_MSG_LEN));
        do_end   = !text_ended_reg
                   && ((c == CH_NUL) || (byte_cnt_reg >= BYTE_CNT_W'(MAX_MSG_LEN))
                       || (cnt_inc >= (BYTE_CNT_W + 1)'(MAX_MSG_LEN))
                       || in_reg.last_byte);
        found    = 1'b0;

        // Digit arithmetic on the magnitude before this byte, saturating.
        int_sum  = SUM_W'(mag_reg) * SUM_W'(10)
                   + SUM_W'(dval) * SUM_W'(pow10(FRAC_DIGITS));
        int_mag  = (int_sum > SUM_W'(POS_LIMIT)) ? POS_LIMIT : MAG_W'(int_sum);
        frac_sum = SUM_W'(mag_reg)
                   + SUM_W'(dval) * SUM_W'(pow10(FRAC_DIGITS - 1 - int'(frac_cnt_reg)));
        frac_mag = (frac_sum > SUM_W'(POS_LIMIT)) ? POS_LIMIT : MAG_W'(frac_sum);
        cur_value = neg_reg ? -POS_W'(mag_reg) : POS_W'(mag_reg);

        if (in_go && feed)
        begin
            byte_cnt_next = BYTE_CNT_W'(cnt_inc);

            // State name after the first open bracket.
            case (name_phase_reg)
                NP_WAIT:
                begin
                    if (c == CH_OPEN)
                    begin
                        name_phase_next = NP_NAME;
                    end
                end
                NP_NAME:
                begin
                    if (c == CH_BAR)
                    begin
                        held_state_next = MS_UNKNOWN;
                        for (int i = 0; i < NUM_NAMES; i++)
                        begin
                            if (!found && name_cand_reg[i]
                                && (NAME_LEN_W'(NAME_LEN[i]) == name_len_reg))
                            begin
                                found           = 1'b1;
                                held_state_next = 3'(i + 1);
                            end
                        end
                        state_upd_next  = 1'b1;
                        name_phase_next = NP_DONE;
                    end
                    else
                    begin
                        for (int i = 0; i < NUM_NAMES; i++)
                        begin
                            if (!((name_len_reg < NAME_LEN_W'(NAME_LEN[i]))
                                  && (NAME_TEXT[i][name_len_reg[2:0]] == c)))
                            begin
                                name_cand_next[i] = 1'b0;
                            end
                        end
                        name_len_next = name_len_reg + 1'b1;
                        if (name_len_next >= NAME_LEN_W'(STATE_WORD_LIMIT))
                        begin
                            name_phase_next = NP_DONE;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            // Position tag search, then the number scanner.
            if (tag_cnt_reg >= TAG_CNT_W'(TAG_LEN))
            begin
                if (num_active_reg)
                begin
                    case (num_sub_reg)
                        NS_START:
                        begin
                            if (c inside {CH_SPACE, [CH_TAB:CH_CR]})
                            begin
                            end
                            else if ((c == CH_PLUS) || (c == CH_MINUS))
                            begin
                                neg_next     = (c == CH_MINUS);
                                num_sub_next = NS_SIGN;
                            end
                            else if (is_digit)
                            begin
                                mag_next     = int_mag;
                                num_sub_next = NS_INT;
                            end
                            else if (c == CH_DOT)
                            begin
                                num_sub_next = NS_DOT;
                            end
                            else
                            begin
                                num_active_next = 1'b0;
                            end
                        end
                        NS_SIGN:
                        begin
                            if (is_digit)
                            begin
                                mag_next     = int_mag;
                                num_sub_next = NS_INT;
                            end
                            else if (c == CH_DOT)
                            begin
                                num_sub_next = NS_DOT;
                            end
                            else
                            begin
                                num_active_next = 1'b0;
                            end
                        end
                        NS_DOT:
                        begin
                            if (is_digit)
                            begin
                                if (frac_cnt_reg < FRAC_CNT_W'(FRAC_DIGITS))
                                begin
                                    mag_next      = frac_mag;
                                    frac_cnt_next = frac_cnt_reg + 1'b1;
                                end
                                num_sub_next = NS_FRAC;
                            end
                            else
                            begin
                                num_active_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            if (is_digit)
                            begin
                                if (num_sub_reg == NS_INT)
                                begin
                                    mag_next = int_mag;
                                end
                                else if (frac_cnt_reg < FRAC_CNT_W'(FRAC_DIGITS))
                                begin
                                    mag_next      = frac_mag;
                                    frac_cnt_next = frac_cnt_reg + 1'b1;
                                end
                            end
                            else if ((c == CH_DOT) && (num_sub_reg == NS_INT))
                            begin
                                num_sub_next = NS_FRAC;
                            end
                            else if (num_axis_reg == AX_Z)
                            begin
                                // Third number ended: commit all three axes.
                                held_x_next     = pend_x_reg;
                                held_y_next     = pend_y_reg;
                                held_z_next     = cur_value;
                                pos_upd_next    = 1'b1;
                                num_active_next = 1'b0;
                            end
                            else if (c == CH_COMMA)
                            begin
                                if (num_axis_reg == AX_X)
                                begin
                                    pend_x_next = cur_value;
                                end
                                else
                                begin
                                    pend_y_next = cur_value;
                                end
                                num_axis_next = num_axis_reg + 1'b1;
                                num_sub_next  = NS_START;
                                mag_next      = '0;
                                neg_next      = 1'b0;
                                frac_cnt_next = '0;
                            end
                            else
                            begin
                                num_active_next = 1'b0;
                            end
                        end
                    endcase
                end
            end
            else if (TAG_TEXT[tag_cnt_reg[2:0]] == c)
            begin
                tag_cnt_next = tag_cnt_reg + 1'b1;
                if (tag_cnt_next == TAG_CNT_W'(TAG_LEN))
                begin
                    num_active_next = 1'b1;
                    num_axis_next   = AX_X;
                    num_sub_next    = NS_START;
                    mag_next        = '0;
                    neg_next        = 1'b0;
                    frac_cnt_next   = '0;
                end
            end
            else
            begin
                tag_cnt_next = (c == CH_M) ? TAG_CNT_W'(1) : '0;
            end
        end

        // End of text: a third number with digits still completes.
        end_value = neg_next ? -POS_W'(mag_next) : POS_W'(mag_next);
        if (in_go && do_end)
        begin
            if (num_active_next && (num_axis_next == AX_Z)
                && ((num_sub_next == NS_INT) || (num_sub_next == NS_FRAC)))
            begin
                held_x_next  = pend_x_next;
                held_y_next  = pend_y_next;
                held_z_next  = end_value;
                pos_upd_next = 1'b1;
            end
            num_active_next = 1'b0;
            text_ended_next = 1'b1;
        end

        // Last byte: emit the result and clear the per-report state.
        if (in_go && in_reg.last_byte)
        begin
            rpt_valid_next        = 1'b1;
            rpt_next.machine_state = held_state_next;
            rpt_next.state_updated = state_upd_next;
            rpt_next.pos_updated   = pos_upd_next;
            rpt_next.pos_x         = held_x_next;
            rpt_next.pos_y         = held_y_next;
            rpt_next.pos_z         = held_z_next;

            byte_cnt_next   = '0;
            text_ended_next = 1'b0;
            name_phase_next = NP_WAIT;
            name_cand_next  = '1;
            name_len_next   = '0;
            tag_cnt_next    = '0;
            num_active_next = 1'b0;
            num_axis_next   = AX_X;
            num_sub_next    = NS_START;
            mag_next        = '0;
            neg_next        = 1'b0;
            frac_cnt_next   = '0;
            pend_x_next     = '0;
            pend_y_next     = '0;
            state_upd_next  = 1'b0;
            pos_upd_next    = 1'b0;
        end
    end

    // Control and parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            rpt_valid_reg   <= 1'b0;
            byte_cnt_reg    <= '0;
            text_ended_reg  <= 1'b0;
            name_phase_reg  <= NP_WAIT;
            name_cand_reg   <= '1;
            name_len_reg    <= '0;
            tag_cnt_reg     <= '0;
            num_active_reg  <= 1'b0;
            num_axis_reg    <= AX_X;
            num_sub_reg     <= NS_START;
            mag_reg         <= '0;
            neg_reg         <= 1'b0;
            frac_cnt_reg    <= '0;
            pend_x_reg      <= '0;
            pend_y_reg      <= '0;
            state_upd_reg   <= 1'b0;
            pos_upd_reg     <= 1'b0;
            held_state_reg  <= MS_UNKNOWN;
            held_x_reg      <= '0;
            held_y_reg      <= '0;
            held_z_reg      <= '0;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            rpt_valid_reg   <= rpt_valid_next;
            byte_cnt_reg    <= byte_cnt_next;
            text_ended_reg  <= text_ended_next;
            name_phase_reg  <= name_phase_next;
            name_cand_reg   <= name_cand_next;
            name_len_reg    <= name_len_next;
            tag_cnt_reg     <= tag_cnt_next;
            num_active_reg  <= num_active_next;
            num_axis_reg    <= num_axis_next;
            num_sub_reg     <= num_sub_next;
            mag_reg         <= mag_next;
            neg_reg         <= neg_next;
            frac_cnt_reg    <= frac_cnt_next;
            pend_x_reg      <= pend_x_next;
            pend_y_reg      <= pend_y_next;
            state_upd_reg   <= state_upd_next;
            pos_upd_reg     <= pos_upd_next;
            held_state_reg  <= held_state_next;
            held_x_reg      <= held_x_next;
            held_y_reg      <= held_y_next;
            held_z_reg      <= held_z_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (msg_valid && !msg_stall)
        begin
            in_reg <= msg;
        end
        rpt_reg <= rpt_next;
    end

    assign rpt_valid = rpt_valid_reg;
    assign rpt       = rpt_reg;

endmodule
